### hdl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared constants for the edge-function triangle rasterizer: box clamps,
// coordinate width, address layout and the item kind codes.
// ----------------------------------------------------------------------------
package efr_pkg;

  // default bounding box clamps (screen size) and vertex width
  localparam int BOX_CLAMP_X = 320;
  localparam int BOX_CLAMP_Y = 240;
  localparam int COORD_BITS  = 11;

  // result coordinate width and planar address layout
  localparam int PIX_BITS  = 11;
  localparam int ADDR_BITS = 16;
  localparam int MASK_BITS = 4;

  localparam logic [ADDR_BITS-1:0] PAGE_BASE_RESET = 16'd16000;

  // item kind codes
  localparam logic KIND_SETUP = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

endpackage

### hdl/edge_function_triangle_rasterizer.sv
// ----------------------------------------------------------------------------
// edge_function_triangle_rasterizer
// Bounding-box walk over a triangle with incremental edge functions; reports
// coverage, mode-X plane mask and planar byte address for each pixel.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+---------------------------------
//  input    | in  | in_valid_i / in_stall_o   | kind_i, ax_i .. cy_i
//  result   | out | out_valid_o / out_stall_i | pixel_valid_o, px_o, py_o,
//           |     |                           | covered_o, plane_mask_o,
//           |     |                           | byte_address_o, last_o
//  config   | in  | cfg_we_i                  | cfg_wdata_i (page base)
//
// One item per clock sustained while the result side does not stall; an item
// passes the input register, the setup register and the result register. Setup
// forms the box and the edge deltas in the first stage and the corner edge values
// (two products per edge) in the second; a walk step does three additions in the
// second. Reset clears the pipeline valids and the busy flag, and restores the
// page base. A stall on the result side holds every stage that is full; empty
// stages still fill, so the pipeline absorbs up to three items under stall.
module edge_function_triangle_rasterizer #(
  parameter int BOX_CLAMP_X = efr_pkg::BOX_CLAMP_X,
  parameter int BOX_CLAMP_Y = efr_pkg::BOX_CLAMP_Y,
  parameter int COORD_BITS  = efr_pkg::COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [COORD_BITS-1:0]        ax_i,
  input  logic signed [COORD_BITS-1:0]        ay_i,
  input  logic signed [COORD_BITS-1:0]        bx_i,
  input  logic signed [COORD_BITS-1:0]        by_i,
  input  logic signed [COORD_BITS-1:0]        cx_i,
  input  logic signed [COORD_BITS-1:0]        cy_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                pixel_valid_o,
  output logic signed [efr_pkg::PIX_BITS-1:0] px_o,
  output logic signed [efr_pkg::PIX_BITS-1:0] py_o,
  output logic                                covered_o,
  output logic [efr_pkg::MASK_BITS-1:0]       plane_mask_o,
  output logic [efr_pkg::ADDR_BITS-1:0]       byte_address_o,
  output logic                                last_o,

  input  logic                                cfg_we_i,
  input  logic [efr_pkg::ADDR_BITS-1:0]       cfg_wdata_i
);

  // coordinate width: vertices plus the clamp constants (up to 1023)
  localparam int CW = ((COORD_BITS > 10) ? COORD_BITS : 10) + 1;
  // vertex difference, box-corner offset, product and edge value widths
  localparam int DW = COORD_BITS + 1;
  localparam int XW = CW + 1;
  localparam int PW = DW + XW;
  localparam int EW = PW + 1;
  localparam int MB = (COORD_BITS < efr_pkg::PIX_BITS) ? COORD_BITS : efr_pkg::PIX_BITS;
  localparam int AW = efr_pkg::ADDR_BITS;

  localparam logic signed [CW-1:0] CLAMP_X = CW'(BOX_CLAMP_X);
  localparam logic signed [CW-1:0] CLAMP_Y = CW'(BOX_CLAMP_Y);

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, out_ready;
  logic s2_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s2_fire    = s2_valid_q && out_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input register, box and edge deltas
  // --------------------------------------------------------------------------
  logic                         s1_kind_q;
  logic signed [COORD_BITS-1:0] s1_vx_q [3];
  logic signed [COORD_BITS-1:0] s1_vy_q [3];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_kind_q  <= kind_i;
      s1_vx_q[0] <= ax_i;
      s1_vy_q[0] <= ay_i;
      s1_vx_q[1] <= bx_i;
      s1_vy_q[1] <= by_i;
      s1_vx_q[2] <= cx_i;
      s1_vy_q[2] <= cy_i;
    end
  end

  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [CW-1:0] min_x_d, min_y_d, max_x_d, max_y_d;
  logic signed [DW-1:0] col_d [3];
  logic signed [DW-1:0] row_d [3];
  logic signed [XW-1:0] dx_d  [3];
  logic signed [XW-1:0] dy_d  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = CW'(s1_vx_q[i]);
      vy[i] = CW'(s1_vy_q[i]);
    end
    // max starts at zero and min at the clamp corner
    min_x_d = smin(smin(CLAMP_X, vx[0]), smin(vx[1], vx[2]));
    min_y_d = smin(smin(CLAMP_Y, vy[0]), smin(vy[1], vy[2]));
    max_x_d = smax(smax('0, vx[0]), smax(vx[1], vx[2]));
    max_y_d = smax(smax('0, vy[0]), smax(vy[1], vy[2]));
  end

  // edge e runs from vertex (e+1)%3 to vertex (e+2)%3;
  // value at the corner = row * (min_y - p.y) + col * (min_x - p.x)
  for (genvar e = 0; e < 3; e++) begin : g_delta
    localparam int P = (e + 1) % 3;
    localparam int Q = (e + 2) % 3;
    assign col_d[e] = DW'(s1_vy_q[P]) - DW'(s1_vy_q[Q]);
    assign row_d[e] = DW'(s1_vx_q[Q]) - DW'(s1_vx_q[P]);
    assign dx_d[e]  = XW'(min_x_d) - XW'(vx[P]);
    assign dy_d[e]  = XW'(min_y_d) - XW'(vy[P]);
  end

  // --------------------------------------------------------------------------
  // stage 2: setup register, walk state and pixel results
  // --------------------------------------------------------------------------
  logic                 s2_kind_q;
  logic signed [CW-1:0] s2_min_x_q, s2_min_y_q, s2_max_x_q, s2_max_y_q;
  logic signed [DW-1:0] s2_col_q [3];
  logic signed [DW-1:0] s2_row_q [3];
  logic signed [XW-1:0] s2_dx_q  [3];
  logic signed [XW-1:0] s2_dy_q  [3];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_kind_q  <= s1_kind_q;
      s2_min_x_q <= min_x_d;
      s2_min_y_q <= min_y_d;
      s2_max_x_q <= max_x_d;
      s2_max_y_q <= max_y_d;
      for (int i = 0; i < 3; i++) begin
        s2_col_q[i] <= col_d[i];
        s2_row_q[i] <= row_d[i];
        s2_dx_q[i]  <= dx_d[i];
        s2_dy_q[i]  <= dy_d[i];
      end
    end
  end

  logic signed [PW-1:0] prod_row [3];
  logic signed [PW-1:0] prod_col [3];
  logic signed [EW-1:0] corner   [3];

  for (genvar e = 0; e < 3; e++) begin : g_corner
    assign prod_row[e] = PW'(s2_row_q[e]) * PW'(s2_dy_q[e]);
    assign prod_col[e] = PW'(s2_col_q[e]) * PW'(s2_dx_q[e]);
    assign corner[e]   = EW'(prod_row[e]) + EW'(prod_col[e]);
  end

  // walk state
  logic                 busy_q;
  logic [AW-1:0]        page_base_q;
  logic signed [CW-1:0] cur_x_q, cur_y_q, min_x_q, max_x_q, max_y_q;
  logic signed [DW-1:0] col_step_q [3];
  logic signed [DW-1:0] row_step_q [3];
  logic signed [EW-1:0] edge_now_q [3];
  logic signed [EW-1:0] edge_row_q [3];

  logic is_setup, is_pixel, end_row, fin, cov;
  logic [AW-1:0] y_ext, x_ext, addr;

  assign is_setup = (s2_kind_q == efr_pkg::KIND_SETUP);
  assign is_pixel = (s2_kind_q == efr_pkg::KIND_STEP) && busy_q;
  assign end_row  = (cur_x_q >= max_x_q);
  assign fin      = end_row && (cur_y_q >= max_y_q);
  assign cov      = (edge_now_q[0] <= 0) && (edge_now_q[1] <= 0) && (edge_now_q[2] <= 0);

  // address = page base + y*80 + floor(x/4), wrapped
  assign y_ext = AW'(cur_y_q);
  assign x_ext = AW'(cur_x_q >>> 2);
  assign addr  = page_base_q + (y_ext << 6) + (y_ext << 4) + x_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      page_base_q <= efr_pkg::PAGE_BASE_RESET;
    end else begin
      if (cfg_we_i) begin
        page_base_q <= cfg_wdata_i;
      end
      if (s2_fire) begin
        if (is_setup) begin
          busy_q <= 1'b1;
        end else if (is_pixel && fin) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      if (is_setup) begin
        // load a new triangle, abandoning any walk in progress
        cur_x_q <= s2_min_x_q;
        cur_y_q <= s2_min_y_q;
        min_x_q <= s2_min_x_q;
        max_x_q <= s2_max_x_q;
        max_y_q <= s2_max_y_q;
        for (int i = 0; i < 3; i++) begin
          col_step_q[i] <= s2_col_q[i];
          row_step_q[i] <= s2_row_q[i];
          edge_now_q[i] <= corner[i];
          edge_row_q[i] <= corner[i];
        end
      end else if (is_pixel && !fin) begin
        if (end_row) begin
          cur_x_q <= min_x_q;
          cur_y_q <= cur_y_q + CW'(1);
          for (int i = 0; i < 3; i++) begin
            edge_row_q[i] <= edge_row_q[i] + EW'(row_step_q[i]);
            edge_now_q[i] <= edge_row_q[i] + EW'(row_step_q[i]);
          end
        end else begin
          cur_x_q <= cur_x_q + CW'(1);
          for (int i = 0; i < 3; i++) begin
            edge_now_q[i] <= edge_now_q[i] + EW'(col_step_q[i]);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic                                pix_q, cov_q, last_q;
  logic signed [efr_pkg::PIX_BITS-1:0] px_q, py_q;
  logic [efr_pkg::MASK_BITS-1:0]       mask_q;
  logic [AW-1:0]                       addr_q;

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      if (is_pixel) begin
        pix_q  <= 1'b1;
        px_q   <= efr_pkg::PIX_BITS'(cur_x_q[MB-1:0]);
        py_q   <= efr_pkg::PIX_BITS'(cur_y_q[MB-1:0]);
        cov_q  <= cov;
        mask_q <= efr_pkg::MASK_BITS'(1) << cur_x_q[1:0];
        addr_q <= addr;
        last_q <= fin;
      end else begin
        // setup or idle step: report an empty result
        pix_q  <= 1'b0;
        px_q   <= '0;
        py_q   <= '0;
        cov_q  <= 1'b0;
        mask_q <= '0;
        addr_q <= '0;
        last_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_valid_o  = pix_q;
  assign px_o           = px_q;
  assign py_o           = py_q;
  assign covered_o      = cov_q;
  assign plane_mask_o   = mask_q;
  assign byte_address_o = addr_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> pixel_valid_o)
    else $error("last flag on a result that is not a pixel");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_valid_o |-> $onehot(plane_mask_o))
    else $error("plane mask not one-hot on a pixel");

  a_busy_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_o && pixel_valid_o && last_o)
    else $error("walk ended without a last pixel");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |-> !covered_o && (plane_mask_o == '0))
    else $error("non-pixel result carries pixel data");
`endif

endmodule

### tb/efr_pixel_checker.sv
// ----------------------------------------------------------------------------
// efr_pixel_checker
// Watches the input, result and page-base ports of the rasterizer. Each
// accepted word goes through a local model of the bounding-box walk. The model
// tracks the edge values, the coverage and the planar address, and queues the
// pixel the word should yield. Each accepted result is checked field by field
// against the oldest queued pixel.
// ----------------------------------------------------------------------------
module efr_pixel_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [efr_pkg::COORD_BITS-1:0] ax_i,
  input  logic signed [efr_pkg::COORD_BITS-1:0] ay_i,
  input  logic signed [efr_pkg::COORD_BITS-1:0] bx_i,
  input  logic signed [efr_pkg::COORD_BITS-1:0] by_i,
  input  logic signed [efr_pkg::COORD_BITS-1:0] cx_i,
  input  logic signed [efr_pkg::COORD_BITS-1:0] cy_i,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic                                pixel_valid_o,
  input  logic signed [efr_pkg::PIX_BITS-1:0] px_o,
  input  logic signed [efr_pkg::PIX_BITS-1:0] py_o,
  input  logic                                covered_o,
  input  logic [efr_pkg::MASK_BITS-1:0]       plane_mask_o,
  input  logic [efr_pkg::ADDR_BITS-1:0]       byte_address_o,
  input  logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [efr_pkg::ADDR_BITS-1:0]       cfg_wdata_i,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BYTES = 80;

  typedef struct packed {
    logic                            pix;
    logic [efr_pkg::PIX_BITS-1:0]    px;
    logic [efr_pkg::PIX_BITS-1:0]    py;
    logic                            cov;
    logic [efr_pkg::MASK_BITS-1:0]   mask;
    logic [efr_pkg::ADDR_BITS-1:0]   addr;
    logic                            fin;
  } pixel_t;

  logic [efr_pkg::ADDR_BITS-1:0] page_base;
  logic                 walking;
  int                   col_x, row_y, left_x, right_x, bottom_y;
  int                   col_step[3], row_step[3], edge_val[3], edge_row[3];
  pixel_t               pixel_q[$];
  pixel_t               want, fresh;
  int                   fails = 0;
  int                   waiting_n = 0;

  assign fail_count = fails;
  assign pending    = waiting_n;

  // signed area of (p, q, r): the edge function of p->q evaluated at r
  function automatic int edge_at(int p_x, int p_y, int q_x, int q_y, int r_x, int r_y);
    return (q_x - p_x) * (r_y - p_y) - (q_y - p_y) * (r_x - p_x);
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // advance the walk model by one input word and return the pixel it yields
  task automatic next_pixel(output pixel_t res);
    int   vx[3], vy[3];
    int   lo_x, lo_y, hi_x, hi_y, addr_full;
    logic row_end;
    res = '0;
    if (kind_i == efr_pkg::KIND_SETUP) begin
      vx[0] = ax_i; vy[0] = ay_i;
      vx[1] = bx_i; vy[1] = by_i;
      vx[2] = cx_i; vy[2] = cy_i;
      lo_x = efr_pkg::BOX_CLAMP_X;
      lo_y = efr_pkg::BOX_CLAMP_Y;
      hi_x = 0;
      hi_y = 0;
      for (int i = 0; i < 3; i++) begin
        if (vx[i] > hi_x) hi_x = vx[i];
        if (vx[i] < lo_x) lo_x = vx[i];
        if (vy[i] > hi_y) hi_y = vy[i];
        if (vy[i] < lo_y) lo_y = vy[i];
      end
      left_x   = lo_x;
      right_x  = hi_x;
      bottom_y = hi_y;
      col_x    = lo_x;
      row_y    = lo_y;
      // edges run b->c, c->a, a->b
      edge_row[0] = edge_at(vx[1], vy[1], vx[2], vy[2], lo_x, lo_y);
      edge_row[1] = edge_at(vx[2], vy[2], vx[0], vy[0], lo_x, lo_y);
      edge_row[2] = edge_at(vx[0], vy[0], vx[1], vy[1], lo_x, lo_y);
      col_step[0] = vy[1] - vy[2];
      col_step[1] = vy[2] - vy[0];
      col_step[2] = vy[0] - vy[1];
      row_step[0] = vx[2] - vx[1];
      row_step[1] = vx[0] - vx[2];
      row_step[2] = vx[1] - vx[0];
      edge_val = edge_row;
      walking  = 1'b1;
    end else if (walking) begin
      row_end   = col_x >= right_x;
      addr_full = int'(page_base) + row_y * ROW_BYTES + (col_x >>> 2);
      res.pix   = 1'b1;
      res.px    = col_x[efr_pkg::PIX_BITS-1:0];
      res.py    = row_y[efr_pkg::PIX_BITS-1:0];
      res.cov   = edge_val[0] <= 0 && edge_val[1] <= 0 && edge_val[2] <= 0;
      res.mask  = 4'b0001 << col_x[1:0];
      res.addr  = addr_full[efr_pkg::ADDR_BITS-1:0];
      res.fin   = row_end && row_y >= bottom_y;
      if (res.fin) begin
        walking = 1'b0;
      end else if (row_end) begin
        for (int i = 0; i < 3; i++) begin
          edge_row[i] += row_step[i];
          edge_val[i] = edge_row[i];
        end
        col_x = left_x;
        row_y++;
      end else begin
        for (int i = 0; i < 3; i++) edge_val[i] += col_step[i];
        col_x++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_base = efr_pkg::PAGE_BASE_RESET;
      walking   = 1'b0;
      col_x     = 0;
      row_y     = 0;
      left_x    = 0;
      right_x   = 0;
      bottom_y  = 0;
      for (int i = 0; i < 3; i++) begin
        col_step[i] = 0;
        row_step[i] = 0;
        edge_val[i] = 0;
        edge_row[i] = 0;
      end
      pixel_q.delete();
      waiting_n = 0;
    end else begin
      if (cfg_we_i) page_base = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $error("result word arrived with no pixel pending");
          fails++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_valid", want.pix, pixel_valid_o);
          check_field("px", $signed(want.px), px_o);
          check_field("py", $signed(want.py), py_o);
          check_field("covered", want.cov, covered_o);
          check_field("plane_mask", want.mask, plane_mask_o);
          check_field("byte_address", want.addr, byte_address_o);
          check_field("last", want.fin, last_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        next_pixel(fresh);
        pixel_q.push_back(fresh);
      end
      waiting_n = pixel_q.size();
    end
  end

endmodule

### tb/edge_function_triangle_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// edge_function_triangle_rasterizer_tb
// Drives setup and step words into the rasterizer with random gaps and result
// stalls. A directed opening covers the vertex extremes, walks from idle,
// abandoned walks and negative coordinates. Random phases follow under several
// page bases: mostly small triangles walked to their last pixel, plus
// full-range setups with short walks and stray steps.
// ----------------------------------------------------------------------------
module edge_function_triangle_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT     = 2000;
  localparam int WORDS_PER_PHASE = 200;
  localparam int PHASES          = 4;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni;
  logic                                   in_valid_i;
  logic                                   in_stall_o;
  logic                                   kind_i;
  logic signed [efr_pkg::COORD_BITS-1:0]  ax_i, ay_i, bx_i, by_i, cx_i, cy_i;
  logic                                   out_valid_o;
  logic                                   out_stall_i;
  logic                                   pixel_valid_o;
  logic signed [efr_pkg::PIX_BITS-1:0]    px_o, py_o;
  logic                                   covered_o;
  logic [efr_pkg::MASK_BITS-1:0]          plane_mask_o;
  logic [efr_pkg::ADDR_BITS-1:0]          byte_address_o;
  logic                                   last_o;
  logic                                   cfg_we_i;
  logic [efr_pkg::ADDR_BITS-1:0]          cfg_wdata_i;
  int                                     fail_count;
  int                                     pending;
  logic                                   calm;
  int                                     words_sent;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  edge_function_triangle_rasterizer dut (.*);

  efr_pixel_checker checker_i (.*);

  function automatic int idle_draw();
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  // pixels along one axis of the box: min clamped to the screen, max to zero
  function automatic int box_extent(int a, int b, int c, int clamp_lo);
    int lo, hi;
    lo = clamp_lo;
    hi = 0;
    if (a < lo) lo = a;
    if (b < lo) lo = b;
    if (c < lo) lo = c;
    if (a > hi) hi = a;
    if (b > hi) hi = b;
    if (c > hi) hi = c;
    return hi - lo + 1;
  endfunction

  // enter and leave at a falling edge
  task automatic send_word(input logic k, input int x0, input int y0, input int x1,
                           input int y1, input int x2, input int y2);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i     = k;
    ax_i       = x0[efr_pkg::COORD_BITS-1:0];
    ay_i       = y0[efr_pkg::COORD_BITS-1:0];
    bx_i       = x1[efr_pkg::COORD_BITS-1:0];
    by_i       = y1[efr_pkg::COORD_BITS-1:0];
    cx_i       = x2[efr_pkg::COORD_BITS-1:0];
    cy_i       = y2[efr_pkg::COORD_BITS-1:0];
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_setup(input int x0, input int y0, input int x1, input int y1,
                            input int x2, input int y2);
    send_word(efr_pkg::KIND_SETUP, x0, y0, x1, y1, x2, y2);
  endtask

  // vertex fields carry noise on step words
  task automatic send_steps(input int n);
    repeat (n) send_word(efr_pkg::KIND_STEP, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
  endtask

  task automatic write_page_base(input logic [efr_pkg::ADDR_BITS-1:0] value);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // result side: draw a stall per word, then take it
  initial begin
    int hold;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int x0, y0, x1, y1, x2, y2;
    int ox, oy, span, pick, n, target;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = efr_pkg::KIND_SETUP;
    ax_i        = '0;
    ay_i        = '0;
    bx_i        = '0;
    by_i        = '0;
    cx_i        = '0;
    cy_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    calm        = 1'b0;
    words_sent  = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // step with no walk, then a 3x2 box walked past its end
    send_steps(1);
    send_setup(0, 0, 2, 0, 0, 1);
    send_steps(7);
    // negative corner: floor address math, then wrap to the next row
    send_setup(-5, -3, -3, -3, -5, -2);
    send_steps(7);
    // vertex extremes; each setup drops the walk in progress
    send_setup(-1024, -1024, 1023, 1023, -1024, 1023);
    send_steps(2);
    send_setup(1023, 1023, 1023, 1023, 1023, 1023);
    send_steps(1);
    send_setup(-1024, -1024, -1024, -1024, -1024, -1024);
    send_steps(1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_page_base('0);
        1: write_page_base('1);
        default: write_page_base(efr_pkg::ADDR_BITS'($urandom));
      endcase
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) begin
        calm = $urandom_range(0, 3) == 0;
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          // small triangle, walked to the last pixel
          span = ($urandom_range(0, 7) == 0) ? 9 : 3;
          ox   = int'($urandom_range(0, 332)) - 10;
          oy   = int'($urandom_range(0, 252)) - 10;
          x0   = ox + int'($urandom_range(0, span));
          y0   = oy + int'($urandom_range(0, span));
          x1   = ox + int'($urandom_range(0, span));
          y1   = oy + int'($urandom_range(0, span));
          x2   = ox + int'($urandom_range(0, span));
          y2   = oy + int'($urandom_range(0, span));
          n    = box_extent(x0, x1, x2, efr_pkg::BOX_CLAMP_X) *
                 box_extent(y0, y1, y2, efr_pkg::BOX_CLAMP_Y);
          send_setup(x0, y0, x1, y1, x2, y2);
          send_steps(n + (($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0));
        end else if (pick < 17) begin
          // full-range setup, short walk, then abandoned
          send_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          send_steps($urandom_range(0, 6));
        end else begin
          send_steps($urandom_range(1, 4));
        end
      end
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
